// ===== src/ctil_pkg.sv =====
// Package for the inverse-CDF table lookup: field widths, parameter defaults,
// command codes. No dependencies.
`default_nettype none
package ctil_pkg;

    localparam int MAX_ENTRIES_DEF   = 1024;
    localparam int WEIGHT_BITS_DEF   = 16;
    localparam int FRACTION_BITS_DEF = 32;

    localparam int CMD_W    = 1;
    localparam int WEIGHT_W = 16;
    localparam int PROB_W   = 32;
    localparam int INDEX_W  = 11;

    localparam logic [CMD_W-1:0] CMD_LOAD  = 1'b0;
    localparam logic [CMD_W-1:0] CMD_QUERY = 1'b1;

endpackage
`default_nettype wire

// ===== src/ctil_in_if.sv =====
// Request channel of the table lookup: load or query transactions.
// Depends on ctil_pkg.
`default_nettype none
interface ctil_in_if;
    import ctil_pkg::*;

    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    cmd;
    logic [WEIGHT_W-1:0] weight;
    logic                first_weight;
    logic [PROB_W-1:0]   probability;

    modport source (output valid, output cmd, output weight, output first_weight,
                    output probability, input ready);
    modport sink   (input valid, input cmd, input weight, input first_weight,
                    input probability, output ready);
endinterface
`default_nettype wire

// ===== src/ctil_out_if.sv =====
// Result channel of the table lookup: one transaction per query.
// Depends on ctil_pkg.
`default_nettype none
interface ctil_out_if;
    import ctil_pkg::*;

    logic               valid;
    logic               ready;
    logic [INDEX_W-1:0] index;
    logic               table_empty;

    modport source (output valid, output index, output table_empty, input ready);
    modport sink   (input valid, input index, input table_empty, output ready);
endinterface
`default_nettype wire

// ===== src/ctil_table_ram.sv =====
// Single-port-write, single-port-read RAM holding the cumulative sums.
// Read data is registered. No dependencies.
`default_nettype none
module ctil_table_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 26
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule
`default_nettype wire

// ===== src/cdf_table_index_lookup.sv =====
// Inverse-CDF table lookup by binary search over stored cumulative sums.
// Depends on ctil_pkg, ctil_in_if, ctil_out_if, ctil_table_ram.
//
// request carries two kinds of transaction. A load (cmd = load) appends one
// weight: the running total grows by it and the new total is written into
// the table; first_weight restarts the table at entry zero. A load gives no
// result, and loads may follow each other every cycle while no query is in
// progress. Loads past MAX_ENTRIES without first_weight are dropped.
// A query (cmd = query) returns on result the first entry whose cumulative
// sum reaches probability * total / 2^FRACTION_BITS, compared exactly.
// The product prob * total is formed once at acceptance and turned into a
// ceiling threshold; then one shared comparator steps the binary search,
// one table read per cycle. After acceptance ST_THR forms the threshold,
// ST_SEARCH steps until lo meets hi, and ST_FINISH registers the result
// and makes request ready again; an empty or zero-total table goes straight
// to ST_FINISH, whose result has table_empty set. request is not ready meanwhile.
// The result sits in an output register; loads go on while it waits, but a
// following query holds request not ready until the register frees.
// Reset empties the table (count and total cleared); table contents are not
// cleared and need no clearing pass.
`default_nettype none
module cdf_table_index_lookup #(
    parameter int MAX_ENTRIES   = ctil_pkg::MAX_ENTRIES_DEF,
    parameter int WEIGHT_BITS   = ctil_pkg::WEIGHT_BITS_DEF,
    parameter int FRACTION_BITS = ctil_pkg::FRACTION_BITS_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    ctil_in_if.sink    request,
    ctil_out_if.source result
);
    import ctil_pkg::*;

    localparam int WB     = (WEIGHT_BITS < WEIGHT_W) ? WEIGHT_BITS : WEIGHT_W;
    localparam int FB     = FRACTION_BITS;
    localparam int AW     = $clog2(MAX_ENTRIES);
    localparam int CW     = $clog2(MAX_ENTRIES + 1);
    localparam int CUM_W  = WB + AW;
    localparam int PROD_W = FB + CUM_W;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_THR    = 4'b0010,
        ST_SEARCH = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    state_t            state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [CUM_W-1:0]  total_reg, total_next;
    logic [CW-1:0]     lo_reg, lo_next;
    logic [CW-1:0]     hi_reg, hi_next;
    logic [CW-1:0]     mid_reg, mid_next;
    logic              empty_reg, empty_next;
    logic [PROD_W-1:0] prod_reg;
    logic [CUM_W:0]    thr_reg;
    logic              out_valid_reg;
    logic [INDEX_W-1:0] out_index_reg;
    logic              out_empty_reg;

    logic              accept;
    logic              is_load;
    logic              is_query;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [CUM_W-1:0]  wr_data;
    logic [CUM_W-1:0]  rd_data;
    logic [CUM_W-1:0]  weight_ext;
    logic              reach;
    logic [CW-1:0]     step_lo, step_hi;
    logic              out_free;

    assign request.ready = (state_reg == ST_IDLE);
    assign accept        = request.valid && request.ready;
    assign is_load       = accept && (request.cmd == CMD_LOAD);
    assign is_query      = accept && (request.cmd == CMD_QUERY);
    assign weight_ext    = CUM_W'(request.weight[WB-1:0]);
    assign out_free      = !out_valid_reg || result.ready;

    // shared comparator: cum * 2^FB >= prod  <=>  cum >= ceil(prod / 2^FB)
    assign reach   = ({1'b0, rd_data} >= thr_reg);
    assign step_lo = reach ? lo_reg : (mid_reg + CW'(1));
    assign step_hi = reach ? mid_reg : hi_reg;

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        total_next = total_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        mid_next   = mid_reg;
        empty_next = empty_reg;
        wr_en      = 1'b0;
        wr_addr    = count_reg[AW-1:0];
        wr_data    = total_reg + weight_ext;

        case (state_reg)
            ST_IDLE:
            begin
                mid_next = count_reg >> 1;
                if (is_load)
                begin
                    if (request.first_weight)
                    begin
                        wr_en      = 1'b1;
                        wr_addr    = '0;
                        wr_data    = weight_ext;
                        total_next = weight_ext;
                        count_next = CW'(1);
                    end
                    else if (count_reg < CW'(MAX_ENTRIES))
                    begin
                        wr_en      = 1'b1;
                        total_next = wr_data;
                        count_next = count_reg + CW'(1);
                    end
                end
                else if (is_query)
                begin
                    lo_next = '0;
                    hi_next = count_reg;
                    if ((count_reg == '0) || (total_reg == '0))
                    begin
                        empty_next = 1'b1;
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        empty_next = 1'b0;
                        state_next = ST_THR;
                    end
                end
            end
            ST_THR:
            begin
                state_next = ST_SEARCH;
            end
            ST_SEARCH:
            begin
                lo_next  = step_lo;
                hi_next  = step_hi;
                mid_next = step_lo + ((step_hi - step_lo) >> 1);
                if (step_lo == step_hi)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            total_reg <= total_next;
            if ((state_reg == ST_FINISH) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        mid_reg   <= mid_next;
        empty_reg <= empty_next;
        if (is_query)
        begin
            prod_reg <= PROD_W'(request.probability[FB-1:0]) * PROD_W'(total_reg);
        end
        if (state_reg == ST_THR)
        begin
            thr_reg <= (CUM_W + 1)'(prod_reg[PROD_W-1:FB])
                       + (CUM_W + 1)'(|prod_reg[FB-1:0]);
        end
        if ((state_reg == ST_FINISH) && out_free)
        begin
            out_index_reg <= INDEX_W'(lo_reg);
            out_empty_reg <= empty_reg;
        end
    end

    ctil_table_ram #(
        .DEPTH (MAX_ENTRIES),
        .WIDTH (CUM_W)
    ) u_table (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (mid_next[AW-1:0]),
        .rd_data (rd_data)
    );

    assign result.valid       = out_valid_reg;
    assign result.index       = out_index_reg;
    assign result.table_empty = out_empty_reg;

endmodule
`default_nettype wire
